// ===== rtl/bbc_pkg.sv =====
// shared types, codes and constants for the block buffer cache controller
// used by bbc_cell and block_buffer_cache_lru_top; no dependencies
package bbc_pkg;

    localparam int SLOTS_DEFAULT   = 16;
    localparam int SECTORS_DEFAULT = 8;

    localparam int SLOT_MAX_W = 6;
    localparam int TAG_W      = 32;
    localparam int COUNT_W    = 8;
    localparam int SECTOR_W   = 35;
    localparam int STATUS_W   = 2;
    localparam int SLOT_OUT_W = 4;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [STATUS_W-1:0] ST_HIT    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RELERR = 2'd3;

    localparam logic OP_ACQUIRE = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [1:0] CMD_NONE = 2'd0;
    localparam logic [1:0] CMD_HIT  = 2'd1;
    localparam logic [1:0] CMD_FILL = 2'd2;
    localparam logic [1:0] CMD_REL  = 2'd3;

    typedef struct packed {
        logic                  op;
        logic [TAG_W-1:0]      blk;
        logic                  rel_ok;
        logic [SLOT_MAX_W-1:0] rel_slot;
    } t_req;

    typedef struct packed {
        logic                  active;
        logic                  hit;
        logic [SLOT_MAX_W-1:0] hit_slot;
        logic [COUNT_W-1:0]    hit_count;
        logic                  hit_valid;
        logic                  found;
        logic [SLOT_MAX_W-1:0] pick;
        logic [SLOT_MAX_W-1:0] pick_rank;
        logic [COUNT_W-1:0]    rel_count;
        logic [SLOT_MAX_W-1:0] rel_rank;
    } t_probe;

    typedef struct packed {
        logic [1:0]            kind;
        logic [SLOT_MAX_W-1:0] slot;
        logic [SLOT_MAX_W-1:0] old_rank;
    } t_cmd;

endpackage

// ===== rtl/block_buffer_cache_lru_top.sv =====
// block buffer cache controller: tag lookup, reference counts, lru replacement
// chains SLOTS bbc_cell instances; uses bbc_pkg
//
// usage:
//   input channel i_in_valid / o_in_ready carries one request item: op 0
//   acquires i_block_number, op 1 releases slot i_slot_index
//   output channel o_out_valid / i_out_ready carries one result item per
//   request: status, slot, sector address (block number times
//   SECTORS_PER_BLOCK on a fill, else zero) and the slot's count after it
//   walk: a probe walks the cell chain one slot per cycle; its result is
//   captured at the chain's end, then registered in the output register
//   intake: no new request is taken until the result is loaded for output
//   reset: every slot empty with count zero, slot i at recency rank i
//   stall: the result waits in the output register; the next request is
//   still taken and walks the chain, then holds until the result is taken
module block_buffer_cache_lru_top #(
    parameter int SLOTS             = bbc_pkg::SLOTS_DEFAULT,
    parameter int SECTORS_PER_BLOCK = bbc_pkg::SECTORS_DEFAULT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_op,
    input  logic [bbc_pkg::TAG_W-1:0]        i_block_number,
    input  logic [bbc_pkg::SLOT_OUT_W-1:0]   i_slot_index,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [bbc_pkg::STATUS_W-1:0]     o_status,
    output logic [bbc_pkg::SLOT_OUT_W-1:0]   o_slot,
    output logic [bbc_pkg::SECTOR_W-1:0]     o_sector_address,
    output logic [bbc_pkg::COUNT_W-1:0]      o_ref_count
);
    import bbc_pkg::*;

    localparam int RANK_W = $clog2(SLOTS);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SWEEP = 2'd1;
    localparam logic [1:0] S_DONE  = 2'd2;

    logic [1:0]            r_state;
    logic                  r_start;
    t_req                  r_req;
    logic [SLOT_OUT_W-1:0] r_slot_index;
    t_probe                r_res;
    t_probe                w_head;
    t_probe                w_probe [SLOTS];
    t_cmd                  w_cmd;
    logic                  w_load;
    logic                  w_accept;

    logic [STATUS_W-1:0]   w_status;
    logic [SLOT_OUT_W-1:0] w_slot;
    logic [SECTOR_W-1:0]   w_sector;
    logic [COUNT_W-1:0]    w_count;
    logic [SECTOR_W-1:0]   w_fill_sector;
    t_cmd                  w_act;

    logic                  r_out_valid;
    logic [STATUS_W-1:0]   r_status;
    logic [SLOT_OUT_W-1:0] r_slot;
    logic [SECTOR_W-1:0]   r_sector;
    logic [COUNT_W-1:0]    r_count;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_load     = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    always_comb begin
        w_head        = '0;
        w_head.active = r_start;
    end

    for (genvar k = 0; k < SLOTS; k++) begin : g_cell
        if (k == 0) begin : g_first
            bbc_cell #(.IDX(k), .RANK_W(RANK_W)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_req   (r_req),
                .i_probe (w_head),
                .o_probe (w_probe[k]),
                .i_cmd   (w_cmd)
            );
        end else begin : g_next
            bbc_cell #(.IDX(k), .RANK_W(RANK_W)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_req   (r_req),
                .i_probe (w_probe[k-1]),
                .o_probe (w_probe[k]),
                .i_cmd   (w_cmd)
            );
        end
    end

    assign w_fill_sector = SECTOR_W'(r_req.blk) * SECTOR_W'(SECTORS_PER_BLOCK);

    always_comb begin
        w_status     = ST_FULL;
        w_slot       = '0;
        w_sector     = '0;
        w_count      = '0;
        w_act        = '0;
        w_act.kind   = CMD_NONE;
        if (r_req.op == OP_RELEASE) begin
            w_slot = r_slot_index;
            if (!r_req.rel_ok || r_res.rel_count == '0) begin
                w_status = ST_RELERR;
            end else begin
                w_status       = ST_HIT;
                w_count        = r_res.rel_count - 1'b1;
                w_act.kind     = CMD_REL;
                w_act.slot     = r_req.rel_slot;
                w_act.old_rank = r_res.rel_rank;
            end
        end else if (r_res.hit) begin
            w_status   = r_res.hit_valid ? ST_HIT : ST_MISS;
            w_slot     = SLOT_OUT_W'(r_res.hit_slot);
            w_sector   = r_res.hit_valid ? '0 : w_fill_sector;
            w_count    = (r_res.hit_count == COUNT_MAX) ? COUNT_MAX
                                                        : r_res.hit_count + 1'b1;
            w_act.kind = CMD_HIT;
            w_act.slot = r_res.hit_slot;
        end else if (r_res.found) begin
            w_status   = ST_MISS;
            w_slot     = SLOT_OUT_W'(r_res.pick);
            w_sector   = w_fill_sector;
            w_count    = COUNT_W'(1);
            w_act.kind = CMD_FILL;
            w_act.slot = r_res.pick;
        end
    end

    always_comb begin
        w_cmd = w_act;
        if (!w_load) begin
            w_cmd.kind = CMD_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_start <= 1'b0;
        end else begin
            r_start <= w_accept;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_SWEEP;
                    end
                end
                S_SWEEP: begin
                    if (w_probe[SLOTS-1].active) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req.op       <= i_op;
            r_req.blk      <= i_block_number;
            r_req.rel_ok   <= (32'(i_slot_index) < SLOTS);
            r_req.rel_slot <= SLOT_MAX_W'(i_slot_index);
            r_slot_index   <= i_slot_index;
        end
        if (r_state == S_SWEEP && w_probe[SLOTS-1].active) begin
            r_res <= w_probe[SLOTS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_status <= w_status;
            r_slot   <= w_slot;
            r_sector <= w_sector;
            r_count  <= w_count;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_slot           = r_slot;
    assign o_sector_address = r_sector;
    assign o_ref_count      = r_count;

endmodule

// ===== rtl/bbc_cell.sv =====
// one buffer slot: tag, flags, reference count and recency rank
// folds its state into the probe passing along the chain; uses bbc_pkg
module bbc_cell #(
    parameter int IDX    = 0,
    parameter int RANK_W = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bbc_pkg::t_req   i_req,
    input  bbc_pkg::t_probe i_probe,
    output bbc_pkg::t_probe o_probe,
    input  bbc_pkg::t_cmd   i_cmd
);
    import bbc_pkg::*;

    localparam logic [SLOT_MAX_W-1:0] ME = SLOT_MAX_W'(IDX);

    logic [TAG_W-1:0]   r_tag;
    logic               r_occ;
    logic               r_valid;
    logic [COUNT_W-1:0] r_count;
    logic [RANK_W-1:0]  r_rank;
    t_probe             r_probe;
    t_probe             n_probe;
    logic [SLOT_MAX_W-1:0] w_rank_ext;

    assign w_rank_ext = SLOT_MAX_W'(r_rank);

    always_comb begin
        n_probe = i_probe;
        if (!i_probe.hit && r_occ && r_tag == i_req.blk) begin
            n_probe.hit       = 1'b1;
            n_probe.hit_slot  = ME;
            n_probe.hit_count = r_count;
            n_probe.hit_valid = r_valid;
        end
        if (r_count == '0 && (!i_probe.found || w_rank_ext > i_probe.pick_rank)) begin
            n_probe.found     = 1'b1;
            n_probe.pick      = ME;
            n_probe.pick_rank = w_rank_ext;
        end
        if (i_req.rel_ok && i_req.rel_slot == ME) begin
            n_probe.rel_count = r_count;
            n_probe.rel_rank  = w_rank_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe <= '0;
        end else begin
            r_probe <= n_probe;
        end
    end

    assign o_probe = r_probe;

    always_ff @(posedge i_clk) begin
        if (i_cmd.kind == CMD_FILL && i_cmd.slot == ME) begin
            r_tag <= i_req.blk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ   <= 1'b0;
            r_valid <= 1'b0;
            r_count <= '0;
            r_rank  <= RANK_W'(IDX);
        end else begin
            case (i_cmd.kind)
                CMD_HIT: begin
                    if (i_cmd.slot == ME) begin
                        r_valid <= 1'b1;
                        if (r_count != COUNT_MAX) begin
                            r_count <= r_count + 1'b1;
                        end
                    end
                end
                CMD_FILL: begin
                    if (i_cmd.slot == ME) begin
                        r_occ   <= 1'b1;
                        r_valid <= 1'b1;
                        r_count <= COUNT_W'(1);
                    end
                end
                CMD_REL: begin
                    if (i_cmd.slot == ME) begin
                        r_count <= r_count - 1'b1;
                        r_rank  <= '0;
                    end else if (w_rank_ext < i_cmd.old_rank) begin
                        r_rank <= r_rank + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule
